[src/iirlp_pkg.sv]
// shared types and constants of the second-order iir lowpass
package iirlp_pkg;

  localparam int COEF_W   = 18;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 5;
  localparam int REG_IDXW = 3;

  // register indexes on the configuration port
  localparam logic [REG_IDXW-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDXW-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDXW-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDXW-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDXW-1:0] REG_A2 = 3'd4;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_RESET  = 2'd1,
    FUNC_START  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_INIT   = 2'd1,
    MODE_READY  = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

endpackage

[src/second_order_iir_lowpass.sv]
// Second-order iir lowpass (direct-form-1 biquad) with start/reset/sample operations and
// status reporting. Every transaction takes one result; the block sustains one transaction per
// clock cycle while the result stream is not stalled. An accepted transaction waits in the input
// register, where the five coefficient multiplies, the sum, rounding and saturation run
// combinationally; when it advances, the history registers update and the result is held in the
// output register until taken. The history recursion through the multiply-accumulate sets the
// rate. Coefficients are signed Q3.14 at byte addresses 0, 4, 8, 12, 16 (b0, b1, b2, a1, a2);
// the user is to write them only while the stream is idle, which the block does not enforce.
module second_order_iir_lowpass #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // apb-style coefficient port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [iirlp_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [iirlp_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [iirlp_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                               cfg_pready,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,  // sample_in
  input  logic [1:0]                         in_tuser,  // func
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   out_tdata, // sample_out
  output logic [2:0]                         out_tuser  // status[1:0], clipped
);

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

  iirlp_pkg::coef_set_t coef;

  // input register
  logic                          in_v_r;
  iirlp_pkg::func_t              func_r;
  logic signed [SAMPLE_BITS-1:0] x_r;

  // filter state
  logic signed [SAMPLE_BITS-1:0] prev_in_r, prev2_in_r, prev_out_r, prev2_out_r;
  logic signed [SAMPLE_BITS-1:0] prev_in_nxt, prev2_in_nxt, prev_out_nxt, prev2_out_nxt;
  logic                          priming_r, priming_nxt;
  iirlp_pkg::mode_t              mode_r, mode_nxt;

  // result register
  logic                          out_v_r;
  logic [SAMPLE_BITS-1:0]        y_r, y_nxt;
  logic [1:0]                    status_r;
  logic                          clip_r, clip_nxt;

  logic signed [SAMPLE_BITS-1:0] mac_y;
  logic                          mac_clip;
  logic                          adv;

  iirlp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .coef    (coef)
  );

  iirlp_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .coef (coef),
    .x    (x_r),
    .x1   (prev_in_r),
    .x2   (prev2_in_r),
    .y1   (prev_out_r),
    .y2   (prev2_out_r),
    .y    (mac_y),
    .clip (mac_clip)
  );

  // a transaction moves from input register to result register
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_comb begin
    prev_in_nxt   = prev_in_r;
    prev2_in_nxt  = prev2_in_r;
    prev_out_nxt  = prev_out_r;
    prev2_out_nxt = prev2_out_r;
    priming_nxt   = priming_r;
    mode_nxt      = mode_r;
    y_nxt         = '0;
    clip_nxt      = 1'b0;
    case (func_r)
      iirlp_pkg::FUNC_START: begin
        prev_in_nxt   = '0;
        prev2_in_nxt  = '0;
        prev_out_nxt  = '0;
        prev2_out_nxt = '0;
        priming_nxt   = 1'b1;
        mode_nxt      = iirlp_pkg::MODE_INIT;
      end
      iirlp_pkg::FUNC_RESET: begin
        prev_in_nxt   = x_r;
        prev2_in_nxt  = x_r;
        prev_out_nxt  = x_r;
        prev2_out_nxt = x_r;
        priming_nxt   = 1'b1;
        if (mode_r != iirlp_pkg::MODE_UNINIT) begin
          mode_nxt = iirlp_pkg::MODE_INIT;
          y_nxt    = x_r;
        end
      end
      iirlp_pkg::FUNC_SAMPLE: begin
        if (mode_r == iirlp_pkg::MODE_UNINIT) begin
          mode_nxt = iirlp_pkg::MODE_ERROR;
        end else if (mode_r != iirlp_pkg::MODE_ERROR) begin
          if (priming_r) begin
            prev_in_nxt   = x_r;
            prev2_in_nxt  = x_r;
            prev_out_nxt  = x_r;
            prev2_out_nxt = x_r;
            priming_nxt   = 1'b0;
            y_nxt         = x_r;
          end else begin
            prev2_in_nxt  = prev_in_r;
            prev_in_nxt   = x_r;
            prev2_out_nxt = prev_out_r;
            prev_out_nxt  = mac_y;
            y_nxt         = mac_y;
            clip_nxt      = mac_clip;
          end
          mode_nxt = iirlp_pkg::MODE_READY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      prev_in_r   <= '0;
      prev2_in_r  <= '0;
      prev_out_r  <= '0;
      prev2_out_r <= '0;
      priming_r   <= 1'b1;
      mode_r      <= iirlp_pkg::MODE_UNINIT;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r     <= 1'b1;
        prev_in_r   <= prev_in_nxt;
        prev2_in_r  <= prev2_in_nxt;
        prev_out_r  <= prev_out_nxt;
        prev2_out_r <= prev2_out_nxt;
        priming_r   <= priming_nxt;
        mode_r      <= mode_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= iirlp_pkg::func_t'(in_tuser);
      x_r    <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (adv) begin
      y_r      <= y_nxt;
      status_r <= mode_nxt;
      clip_r   <= clip_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = DW'(y_r);
  assign out_tuser  = {clip_r, status_r};

  // sample while uninitialized lands in error
  a_uninit_err: assert property (@(posedge clk) disable iff (!rst_n)
    adv && func_r == iirlp_pkg::FUNC_SAMPLE && mode_r == iirlp_pkg::MODE_UNINIT
    |=> mode_r == iirlp_pkg::MODE_ERROR && status_r == iirlp_pkg::MODE_ERROR)
    else $error("sample while uninitialized did not set error");

  // error is left only by start or reset to value
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == iirlp_pkg::MODE_ERROR
    && !(adv && func_r == iirlp_pkg::FUNC_START)
    && !(adv && func_r == iirlp_pkg::FUNC_RESET)
    |=> mode_r == iirlp_pkg::MODE_ERROR)
    else $error("error mode left without start or reset");

  // priming sample passes through and clears priming
  a_prime: assert property (@(posedge clk) disable iff (!rst_n)
    adv && priming_r && func_r == iirlp_pkg::FUNC_SAMPLE && mode_r == iirlp_pkg::MODE_INIT
    |=> !priming_r && y_r == $past(x_r) && prev_out_r == $past(x_r))
    else $error("priming sample mishandled");

  // saturation only on a filtered result
  a_clip_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && clip_r |-> status_r == iirlp_pkg::MODE_READY)
    else $error("clipped set outside ready");

  // a waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(x_r) && $stable(func_r))
    else $error("input register lost a waiting transaction");

endmodule

[src/iirlp_cfg.sv]
// coefficient register bank behind the apb-style configuration port
module iirlp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iirlp_pkg::CFG_AW-1:0]      paddr,
  input  logic [iirlp_pkg::CFG_DW-1:0]      pwdata,
  output logic [iirlp_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready,
  output iirlp_pkg::coef_set_t              coef
);

  iirlp_pkg::coef_set_t               coef_r;
  logic [iirlp_pkg::REG_IDXW-1:0]     idx;
  logic                               wr_en;
  logic signed [iirlp_pkg::COEF_W-1:0] rd_coef;

  assign idx    = paddr[iirlp_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign coef   = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      case (idx)
        iirlp_pkg::REG_B0: coef_r.b0 <= pwdata[iirlp_pkg::COEF_W-1:0];
        iirlp_pkg::REG_B1: coef_r.b1 <= pwdata[iirlp_pkg::COEF_W-1:0];
        iirlp_pkg::REG_B2: coef_r.b2 <= pwdata[iirlp_pkg::COEF_W-1:0];
        iirlp_pkg::REG_A1: coef_r.a1 <= pwdata[iirlp_pkg::COEF_W-1:0];
        iirlp_pkg::REG_A2: coef_r.a2 <= pwdata[iirlp_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      iirlp_pkg::REG_B0: rd_coef = coef_r.b0;
      iirlp_pkg::REG_B1: rd_coef = coef_r.b1;
      iirlp_pkg::REG_B2: rd_coef = coef_r.b2;
      iirlp_pkg::REG_A1: rd_coef = coef_r.a1;
      iirlp_pkg::REG_A2: rd_coef = coef_r.a2;
      default:           rd_coef = '0;
    endcase
  end

  assign prdata = {{(iirlp_pkg::CFG_DW - iirlp_pkg::COEF_W){1'b0}}, rd_coef};

endmodule

[src/iirlp_mac.sv]
// five-tap multiply-accumulate with round half up and saturation
module iirlp_mac #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  iirlp_pkg::coef_set_t           coef,
  input  logic signed [SAMPLE_BITS-1:0]  x,
  input  logic signed [SAMPLE_BITS-1:0]  x1,
  input  logic signed [SAMPLE_BITS-1:0]  x2,
  input  logic signed [SAMPLE_BITS-1:0]  y1,
  input  logic signed [SAMPLE_BITS-1:0]  y2,
  output logic signed [SAMPLE_BITS-1:0]  y,
  output logic                           clip
);

  localparam int PROD_W = iirlp_pkg::COEF_W + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 3;
  localparam int ACC_W  = (SUM_W > COEF_FRAC_BITS + 2) ? SUM_W : COEF_FRAC_BITS + 2;

  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;

  assign p_b0 = coef.b0 * x;
  assign p_b1 = coef.b1 * x1;
  assign p_b2 = coef.b2 * x2;
  assign p_a1 = coef.a1 * y1;
  assign p_a2 = coef.a2 * y2;

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;

  // arithmetic shift gives the floor
  assign shifted = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > Y_MAX) begin
      y    = Y_MAX[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (shifted < Y_MIN) begin
      y    = Y_MIN[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else begin
      y    = shifted[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench of the second-order iir lowpass: stream stimulus, biquad prediction
module testbench;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 14;
  localparam longint Y_MAX = 32767;
  localparam longint Y_MIN = -32768;

  typedef struct {
    logic [1:0]          func;
    logic [SAMPLE_W-1:0] sample;
  } filt_cmd_t;

  typedef struct {
    logic [SAMPLE_W-1:0] y;
    iirlp_pkg::mode_t    status;
    logic                clip;
  } filt_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [iirlp_pkg::CFG_AW-1:0]    cfg_paddr   = '0;
  logic [iirlp_pkg::CFG_DW-1:0]    cfg_pwdata  = '0;
  logic [iirlp_pkg::CFG_DW-1:0]    cfg_prdata;
  logic                            cfg_pready;

  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;  // sample_in
  logic [1:0]          in_tuser   = '0;  // func
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;        // sample_out
  logic [2:0]          out_tuser;        // status[1:0], clipped

  // predictor state
  logic signed [iirlp_pkg::COEF_W-1:0] gains [5];
  logic signed [SAMPLE_W-1:0]          x_d1, x_d2, y_d1, y_d2;
  logic                                prime_pending;
  iirlp_pkg::mode_t                    filt_mode;

  filt_cmd_t    pending_cmds[$];
  filt_result_t expected_results[$];
  filt_cmd_t    next_cmd;
  filt_result_t want;

  int  mismatches = 0;
  bit  no_idle = 1'b0;
  int  in_gap = 0;
  int  stall_left = 0;
  logic in_sent = 1'b0;
  logic out_got = 1'b0;

  second_order_iir_lowpass dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void fill_history(input logic signed [SAMPLE_W-1:0] v);
    x_d1 = v;
    x_d2 = v;
    y_d1 = v;
    y_d2 = v;
  endfunction

  // one step of the biquad and its status machine, expectation queued
  function automatic void biquad_step(input logic [1:0] fn,
                                      input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint y;
    filt_result_t r;
    r.y = '0;
    r.clip = 1'b0;
    case (fn)
      iirlp_pkg::FUNC_START: begin
        fill_history('0);
        prime_pending = 1'b1;
        filt_mode = iirlp_pkg::MODE_INIT;
      end
      iirlp_pkg::FUNC_RESET: begin
        fill_history(x);
        prime_pending = 1'b1;
        if (filt_mode != iirlp_pkg::MODE_UNINIT) begin
          filt_mode = iirlp_pkg::MODE_INIT;
          r.y = x;
        end
      end
      iirlp_pkg::FUNC_SAMPLE: begin
        if (filt_mode == iirlp_pkg::MODE_UNINIT) begin
          filt_mode = iirlp_pkg::MODE_ERROR;
        end else if (filt_mode != iirlp_pkg::MODE_ERROR) begin
          if (prime_pending) begin
            fill_history(x);
            prime_pending = 1'b0;
            r.y = x;
          end else begin
            acc = longint'(gains[iirlp_pkg::REG_B0]) * longint'(x)
                + longint'(gains[iirlp_pkg::REG_B1]) * longint'(x_d1)
                + longint'(gains[iirlp_pkg::REG_B2]) * longint'(x_d2)
                - longint'(gains[iirlp_pkg::REG_A1]) * longint'(y_d1)
                - longint'(gains[iirlp_pkg::REG_A2]) * longint'(y_d2);
            // round half up, then floor shift
            acc += longint'(1) << (FRAC_W - 1);
            y = acc >>> FRAC_W;
            if (y > Y_MAX) begin
              y = Y_MAX;
              r.clip = 1'b1;
            end else if (y < Y_MIN) begin
              y = Y_MIN;
              r.clip = 1'b1;
            end
            x_d2 = x_d1;
            x_d1 = x;
            y_d2 = y_d1;
            y_d1 = y[SAMPLE_W-1:0];
            r.y = y[SAMPLE_W-1:0];
          end
          filt_mode = iirlp_pkg::MODE_READY;
        end
      end
      default: ;
    endcase
    r.status = filt_mode;
    expected_results.push_back(r);
  endfunction

  // input side: driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_sent) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        in_tuser <= next_cmd.func;
        in_tdata <= next_cmd.sample;
        in_tvalid <= 1'b1;
        in_gap <= no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // input side: monitor and prediction
  always @(posedge clk) begin
    in_sent <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      biquad_step(in_tuser, in_tdata);
  end

  // result side: ready stalls drawn per transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      if (out_got)
        stall_left = no_idle ? 0 : $urandom_range(0, 4);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result side: monitor and compare
  always @(posedge clk) begin
    out_got <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: y=%0d tuser=%b",
                                  $signed(out_tdata), out_tuser));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.y)
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    $signed(out_tdata), $signed(want.y)));
        if (out_tuser[1:0] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser[1:0], want.status));
        if (out_tuser[2] !== want.clip)
          report_mismatch($sformatf("clipped %b, expected %b", out_tuser[2], want.clip));
      end
    end
  end

  task automatic write_gain(input logic [iirlp_pkg::REG_IDXW-1:0] idx, input int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    gains[idx] = value[iirlp_pkg::COEF_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_gains(input int b0, input int b1, input int b2,
                               input int a1, input int a2);
    write_gain(iirlp_pkg::REG_B0, b0);
    write_gain(iirlp_pkg::REG_B1, b1);
    write_gain(iirlp_pkg::REG_B2, b2);
    write_gain(iirlp_pkg::REG_A1, a1);
    write_gain(iirlp_pkg::REG_A2, a2);
  endtask

  function automatic int random_gain();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1:    return 16'(int'($urandom_range(0, 400)) - 200);
      2:       return 16'h7fff;
      3:       return 16'h8000;
      4:       return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_cmd(input logic [1:0] fn, input logic [SAMPLE_W-1:0] v);
    filt_cmd_t c;
    c.func = fn;
    c.sample = v;
    pending_cmds.push_back(c);
  endfunction

  // start, reload or neither, then a burst of samples with the odd unused selector
  function automatic int queue_random_run();
    int head;
    int len;
    int n;
    head = $urandom_range(0, 19);
    n = 0;
    if (head < 9) begin
      push_cmd(iirlp_pkg::FUNC_START, 16'($urandom));
      n++;
    end else if (head < 18) begin
      push_cmd(iirlp_pkg::FUNC_RESET, pick_sample());
      n++;
    end
    len = $urandom_range(1, 24);
    repeat (len) begin
      if ($urandom_range(0, 29) == 0) begin
        push_cmd(FUNC_UNUSED, 16'($urandom));
      end else begin
        push_cmd(iirlp_pkg::FUNC_SAMPLE, pick_sample());
        n++;
      end
    end
    return n;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int queued;
    for (int i = 0; i < 5; i++) gains[i] = '0;
    fill_history('0);
    prime_pending = 1'b1;
    filt_mode = iirlp_pkg::MODE_UNINIT;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // status machine from reset, zero gains
    push_cmd(iirlp_pkg::FUNC_RESET, 16'h1234);
    push_cmd(FUNC_UNUSED, 16'h5555);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h0007);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h7fff);
    push_cmd(iirlp_pkg::FUNC_RESET, 16'h8000);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h7fff);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h0005);
    wait_idle();

    // extreme gains drive saturation both ways
    program_gains(131071, -131072, 131071, -131072, 131071);
    push_cmd(iirlp_pkg::FUNC_START, 16'h0000);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h7fff);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h7fff);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h8000);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'hffff);
    push_cmd(FUNC_UNUSED, 16'haaaa);
    push_cmd(iirlp_pkg::FUNC_RESET, 16'd100);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'hff9c);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h8000);
    wait_idle();

    // half gain: rounding ties go up
    program_gains(8192, 0, 0, 0, 0);
    push_cmd(iirlp_pkg::FUNC_START, 16'h0000);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h0003);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h0001);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'hffff);
    push_cmd(iirlp_pkg::FUNC_SAMPLE, 16'h0003);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      no_idle = (ph % 3 == 1);
      case (ph)
        0:       program_gains(1106, 2212, 1106, -18725, 6763);
        1:       program_gains(131071, 131071, 131071, 131071, 131071);
        2:       program_gains(-131072, -131072, -131072, -131072, -131072);
        3:       program_gains(0, 0, 0, 0, 0);
        4:       program_gains(16384, 0, 0, 0, 0);
        5:       program_gains(random_gain() / 8, random_gain() / 8, random_gain() / 8,
                               random_gain() / 8, random_gain() / 16);
        default: program_gains(random_gain(), random_gain(), random_gain(),
                               random_gain(), random_gain());
      endcase
      queued = 0;
      while (queued < 150) queued += queue_random_run();
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/iirlp_pkg.sv
src/iirlp_cfg.sv
src/iirlp_mac.sv
src/second_order_iir_lowpass.sv
tb/testbench.sv
